### rtl/core/bal_pkg.sv
// ----------------------------------------------------------------------------
// Balance controller package
// Shared types, constants and register codes of the balancing motor control.
// ----------------------------------------------------------------------------
package bal_pkg;

  // Setpoint steering constants
  localparam int SlewStep    = 10;
  localparam int PosLimit    = 5000;
  localparam int AvoidLoad   = 5000;
  localparam int DistDiv     = 301;
  localparam int BattMin     = 14500;
  localparam int OvrLoad     = 700;
  localparam int UprightBand = 450000;
  localparam int StillBand   = 100;

  // Serial divider geometry
  localparam int DvdW = 32;
  localparam int DsrW = 23;

  // Configuration register codes
  typedef enum logic [2:0] {
    CfgSpeedGain     = 3'd0,
    CfgPositionGain  = 3'd1,
    CfgAngleDivisor  = 3'd2,
    CfgRateDivisor   = 3'd3,
    CfgAutonomous    = 3'd4,
    CfgRemoteHold    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] speed_gain;
    logic signed [15:0] position_gain;
    logic [14:0]        angle_divisor;
    logic [14:0]        rate_divisor;
    logic               autonomous_mode;
    logic [14:0]        remote_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         cmd_flags;
    logic signed [15:0] remote_value;
    logic [15:0]        front_distance;
    logic               left_farther;
    logic               tick_parity;
    logic signed [15:0] body_speed;
    logic signed [16:0] wheel_speed_sum;
    logic signed [31:0] tilt_angle;
    logic signed [31:0] tilt_rate;
    logic signed [15:0] position_meas;
    logic signed [15:0] diff_side_meas;
    logic [15:0]        battery_mv;
  } item_t;

  // Status from the setpoint unit to the top level
  typedef struct packed {
    logic signed [15:0] position_set;
    logic signed [15:0] turn_set;
    logic               override_active;
  } ctl_stat_t;

endpackage

### rtl/core/bal_cmd_if.sv
// ----------------------------------------------------------------------------
// Measurement channel
// Valid/ready channel carrying one control tick of measurements and flags.
// ----------------------------------------------------------------------------
interface bal_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd_flags;
  logic signed [15:0] remote_value;
  logic [15:0]        front_distance;
  logic               left_farther;
  logic               tick_parity;
  logic signed [15:0] body_speed;
  logic signed [16:0] wheel_speed_sum;
  logic signed [31:0] tilt_angle;
  logic signed [31:0] tilt_rate;
  logic signed [15:0] position_meas;
  logic signed [15:0] diff_side_meas;
  logic [15:0]        battery_mv;

  modport source (
    output valid, cmd_flags, remote_value, front_distance, left_farther, tick_parity,
           body_speed, wheel_speed_sum, tilt_angle, tilt_rate, position_meas,
           diff_side_meas, battery_mv,
    input  ready
  );
  modport sink (
    input  valid, cmd_flags, remote_value, front_distance, left_farther, tick_parity,
           body_speed, wheel_speed_sum, tilt_angle, tilt_rate, position_meas,
           diff_side_meas, battery_mv,
    output ready
  );
endinterface

### rtl/core/bal_res_if.sv
// ----------------------------------------------------------------------------
// Motor power channel
// Valid/ready channel carrying motor power and setpoints of one tick.
// ----------------------------------------------------------------------------
interface bal_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] power_left;
  logic signed [15:0] power_right;
  logic signed [15:0] position_setpoint;
  logic signed [15:0] turn_setpoint;
  logic               override_active;

  modport source (
    output valid, power_left, power_right, position_setpoint, turn_setpoint,
           override_active,
    input  ready
  );
  modport sink (
    input  valid, power_left, power_right, position_setpoint, turn_setpoint,
           override_active,
    output ready
  );
endinterface

### rtl/core/bal_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface bal_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/bal_ctl.sv
// ----------------------------------------------------------------------------
// Setpoint and override unit
// Holds the motion setpoints, remote and avoid timers and the recovery
// override countdown, and advances them once per tick.
// ----------------------------------------------------------------------------
module bal_ctl (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  bal_pkg::item_t    item,
  input  bal_pkg::cfg_t     cfg,
  output bal_pkg::ctl_stat_t stat
);

  localparam logic signed [21:0] PosHi = 22'(bal_pkg::PosLimit);
  localparam logic signed [21:0] PosLo = -22'(bal_pkg::PosLimit);

  logic signed [15:0] position_set, position_set_next;
  logic signed [15:0] turn_set, turn_set_next;
  logic [14:0]        remote_count, remote_count_next;
  logic signed [15:0] last_remote, last_remote_next;
  logic [12:0]        avoid_timeout, avoid_timeout_next;
  logic signed [2:0]  turn_direction, turn_direction_next;
  logic [9:0]         override_count, override_count_next;

  logic               disabled, ovr_req, remote_rx;
  logic signed [21:0] r20, lo, hi, p;
  logic [2:0]         dq;
  logic signed [3:0]  drive;
  logic signed [2:0]  turn_v;
  logic [14:0]        rc0;
  logic [9:0]         oc0;
  logic               upright, still, same_sign;

  // Next state of all setpoint registers for one tick
  always_comb begin
    disabled  = item.cmd_flags[0];
    ovr_req   = item.cmd_flags[1];
    remote_rx = item.cmd_flags[2];

    position_set_next   = position_set;
    turn_set_next       = turn_set;
    last_remote_next    = last_remote;
    avoid_timeout_next  = avoid_timeout;
    turn_direction_next = turn_direction;

    // Remote slew and clamp
    r20 = (22'(item.remote_value) <<< 4) + (22'(item.remote_value) <<< 2);
    lo  = 22'(last_remote) - 22'(bal_pkg::SlewStep);
    hi  = 22'(last_remote) + 22'(bal_pkg::SlewStep);
    p   = r20;
    if (p < lo) begin
      p = lo;
    end else if (p > hi) begin
      p = hi;
    end
    if (p < PosLo) begin
      p = PosLo;
    end else if (p > PosHi) begin
      p = PosHi;
    end

    // Distance to drive step: quotient by the distance step, saturated at 7
    dq = 3'd0;
    for (int k = 1; k < 8; k++) begin
      if (item.front_distance >= 16'(bal_pkg::DistDiv * k)) begin
        dq = 3'(k);
      end
    end
    drive  = 4'(signed'({1'b0, dq})) - 4'sd2;
    turn_v = item.left_farther ? 3'sd1 : -3'sd1;

    rc0 = remote_rx ? cfg.remote_hold_ticks : remote_count;
    remote_count_next = rc0;

    if (rc0 != 15'd0) begin
      remote_count_next  = rc0 - 15'd1;
      position_set_next  = 16'(p);
      last_remote_next   = 16'(p);
      avoid_timeout_next = 13'(bal_pkg::AvoidLoad);
    end else if (cfg.autonomous_mode) begin
      if (item.body_speed < -16'(bal_pkg::StillBand)) begin
        avoid_timeout_next  = 13'(bal_pkg::AvoidLoad);
        turn_direction_next = item.tick_parity ? -3'sd2 : 3'sd2;
      end
      if (disabled) begin
        avoid_timeout_next = 13'(bal_pkg::AvoidLoad);
      end
      if (avoid_timeout_next != 13'd0) begin
        avoid_timeout_next = avoid_timeout_next - 13'd1;
      end else if (drive <= 4'sd0) begin
        turn_v = turn_direction_next;
      end
      position_set_next = position_set + 16'(drive);
      turn_set_next     = turn_set + 16'(turn_v);
    end

    if (disabled) begin
      position_set_next = '0;
      turn_set_next     = '0;
    end

    // Recovery override countdown
    oc0 = override_count;
    if (ovr_req) begin
      oc0 = (item.battery_mv > 16'(bal_pkg::BattMin)) ? 10'(bal_pkg::OvrLoad) : 10'd0;
    end
    override_count_next = (oc0 != 10'd0) ? oc0 - 10'd1 : 10'd0;
    if (override_count_next != 10'd0) begin
      position_set_next = '0;
    end

    // Early end when near upright and still
    upright = (item.tilt_angle < 32'(bal_pkg::UprightBand)) &&
              (item.tilt_angle > -32'(bal_pkg::UprightBand));
    still = (item.body_speed < 16'(bal_pkg::StillBand)) &&
            (item.body_speed > -16'(bal_pkg::StillBand));
    same_sign = ((item.tilt_angle == 32'sd0) && (item.tilt_rate == 32'sd0)) ||
                ((item.tilt_angle > 32'sd0) && (item.tilt_rate > 32'sd0)) ||
                (item.tilt_angle[31] && item.tilt_rate[31]);
    if ((override_count_next != 10'd0) && upright && still && same_sign) begin
      override_count_next = 10'd0;
    end
  end

  // State registers, advanced once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      position_set   <= '0;
      turn_set       <= '0;
      remote_count   <= '0;
      last_remote    <= '0;
      avoid_timeout  <= '0;
      turn_direction <= '0;
      override_count <= '0;
    end else if (step) begin
      position_set   <= position_set_next;
      turn_set       <= turn_set_next;
      remote_count   <= remote_count_next;
      last_remote    <= last_remote_next;
      avoid_timeout  <= avoid_timeout_next;
      turn_direction <= turn_direction_next;
      override_count <= override_count_next;
    end
  end

  assign stat.position_set    = position_set;
  assign stat.turn_set        = turn_set;
  assign stat.override_active = (override_count != 10'd0);

endmodule

### rtl/core/bal_mac.sv
// ----------------------------------------------------------------------------
// Serial angle target multiplier
// Forms wheel_speed_sum * speed_gain + position_meas * position_gain, one
// gain bit per cycle, wrapped to 32 bits.
// ----------------------------------------------------------------------------
module bal_mac (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [16:0] wsum,
  input  logic signed [15:0] pmeas,
  input  logic signed [15:0] sgain,
  input  logic signed [15:0] pgain,
  output logic               done,
  output logic        [31:0] acc
);

  logic        busy;
  logic [3:0]  cnt;
  logic [31:0] ma, mb;
  logic [15:0] ga, gb;
  logic [31:0] ta, tb;

  // Partial products of the current gain bit
  always_comb begin
    ta = ga[0] ? ma : '0;
    tb = gb[0] ? mb : '0;
  end

  // Shift-add sequence; the top gain bit carries negative weight
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        ma   <= 32'(wsum);
        mb   <= 32'(pmeas);
        ga   <= sgain;
        gb   <= pgain;
        acc  <= '0;
      end else if (busy) begin
        if (cnt == 4'd15) begin
          acc  <= acc - ta - tb;
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          acc <= acc + ta + tb;
        end
        ma  <= ma << 1;
        mb  <= mb << 1;
        ga  <= ga >> 1;
        gb  <= gb >> 1;
        cnt <= cnt + 4'd1;
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("multiplier done without a running sequence");

endmodule

### rtl/core/bal_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division of a signed 32-bit dividend by an unsigned divisor,
// one quotient bit per cycle, truncating toward zero, result wrapped to 16.
// ----------------------------------------------------------------------------
module bal_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [bal_pkg::DvdW-1:0] dividend,
  input  logic        [bal_pkg::DsrW-1:0] divisor,
  output logic                          done,
  output logic signed [15:0]            quotient
);

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t                  state;
  logic [4:0]               cnt;
  logic                     neg;
  logic [bal_pkg::DvdW-1:0] q;
  logic [bal_pkg::DsrW-1:0] d;
  logic [bal_pkg::DsrW-1:0] rem;
  logic [bal_pkg::DsrW:0]   trial, sub;
  logic                     ge;

  // One restoring step
  always_comb begin
    trial = {rem, q[bal_pkg::DvdW-1]};
    sub   = trial - {1'b0, d};
    ge    = (trial >= {1'b0, d});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (start) begin
            neg   <= dividend[bal_pkg::DvdW-1];
            q     <= dividend[bal_pkg::DvdW-1] ? -dividend : dividend;
            d     <= divisor;
            rem   <= '0;
            cnt   <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem <= ge ? sub[bal_pkg::DsrW-1:0] : trial[bal_pkg::DsrW-1:0];
          q   <= {q[bal_pkg::DvdW-2:0], ge};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  // Sign restored on the low 16 bits of the magnitude
  assign quotient = neg ? -signed'(q[15:0]) : signed'(q[15:0]);

  a_done_from_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == D_RUN))
    else $error("divider done outside a division");

endmodule

### rtl/core/balance_robot_motor_control_top.sv
// ----------------------------------------------------------------------------
// Balancing robot motor control
// PD balance controller with remote and obstacle driven setpoint steering.
//
//   Channel  Direction  Carries
//   cmd      in         measurements and command flags of one control tick
//   res      out        left/right motor power, setpoints, override flag
//   cfg      in         register index and write data
//
// Each tick runs a setpoint update, the bit-serial angle target multiplier with
// its start and done handoffs, two runs of the shared serial divider and an
// output step, then returns to idle before the next transaction is accepted.
// Reset is synchronous and restores the sequencer, handshake, configuration and
// setpoint registers and the control state of the multiplier and divider; the
// data registers are not reset. A finished result waits in the output register
// while the next transaction is taken; the block stalls before loading it until it is taken.
// ----------------------------------------------------------------------------
module balance_robot_motor_control_top (
  input logic       clk,
  input logic       rst,
  bal_cmd_if.sink   cmd,
  bal_res_if.source res,
  bal_cfg_if.sink   cfg
);

  typedef enum logic [2:0] {S_IDLE, S_CTL, S_MUL, S_DIVA, S_DIVR, S_OUT} state_t;

  state_t              state;
  bal_pkg::cfg_t       cfg_r;
  bal_pkg::item_t      item_r;
  bal_pkg::ctl_stat_t  stat;
  logic                mac_start, mac_done;
  logic [31:0]         mac_acc;
  logic                div_start, div_done;
  logic signed [15:0]  div_quo;
  logic signed [31:0]  dvd_r;
  logic [bal_pkg::DsrW-1:0] dsr_r;
  logic signed [15:0]  by_angle, by_rate;
  logic [14:0]         adiv1, rdiv1;
  logic [bal_pkg::DsrW-1:0] adsr, rdsr;
  logic                res_valid;

  // Configuration registers; zero divisors act as one
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_r.speed_gain        <= '0;
      cfg_r.position_gain     <= '0;
      cfg_r.angle_divisor     <= 15'd1;
      cfg_r.rate_divisor      <= 15'd1;
      cfg_r.autonomous_mode   <= 1'b0;
      cfg_r.remote_hold_ticks <= 15'd100;
    end else if (cfg.valid) begin
      case (bal_pkg::cfg_idx_t'(cfg.index))
        bal_pkg::CfgSpeedGain:    cfg_r.speed_gain        <= signed'(cfg.data);
        bal_pkg::CfgPositionGain: cfg_r.position_gain     <= signed'(cfg.data);
        bal_pkg::CfgAngleDivisor: cfg_r.angle_divisor     <= cfg.data[14:0];
        bal_pkg::CfgRateDivisor:  cfg_r.rate_divisor      <= cfg.data[14:0];
        bal_pkg::CfgAutonomous:   cfg_r.autonomous_mode   <= cfg.data[0];
        bal_pkg::CfgRemoteHold:   cfg_r.remote_hold_ticks <= cfg.data[14:0];
        default: ;
      endcase
    end
  end

  // Effective divisors including the fixed scale factors
  always_comb begin
    adiv1 = (cfg_r.angle_divisor == 15'd0) ? 15'd1 : cfg_r.angle_divisor;
    rdiv1 = (cfg_r.rate_divisor == 15'd0) ? 15'd1 : cfg_r.rate_divisor;
    adsr  = stat.override_active ?
            (bal_pkg::DsrW'(adiv1) << 4) + (bal_pkg::DsrW'(adiv1) << 3) :
            (bal_pkg::DsrW'(adiv1) << 4);
    rdsr  = bal_pkg::DsrW'(rdiv1) << 8;
  end

  bal_ctl u_ctl (
    .clk  (clk),
    .rst  (rst),
    .step (state == S_CTL),
    .item (item_r),
    .cfg  (cfg_r),
    .stat (stat)
  );

  bal_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .start (mac_start),
    .wsum  (item_r.wheel_speed_sum),
    .pmeas (item_r.position_meas),
    .sgain (cfg_r.speed_gain),
    .pgain (cfg_r.position_gain),
    .done  (mac_done),
    .acc   (mac_acc)
  );

  bal_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dvd_r),
    .divisor  (dsr_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign cmd.ready = (state == S_IDLE);
  assign res.valid = res_valid;

  // Tick sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mac_start <= 1'b0;
      div_start <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      mac_start <= 1'b0;
      div_start <= 1'b0;
      // The output step reloads the register itself when the result is taken.
      if (res_valid && res.ready && (state != S_OUT)) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            item_r.cmd_flags       <= cmd.cmd_flags;
            item_r.remote_value    <= cmd.remote_value;
            item_r.front_distance  <= cmd.front_distance;
            item_r.left_farther    <= cmd.left_farther;
            item_r.tick_parity     <= cmd.tick_parity;
            item_r.body_speed      <= cmd.body_speed;
            item_r.wheel_speed_sum <= cmd.wheel_speed_sum;
            item_r.tilt_angle      <= cmd.tilt_angle;
            item_r.tilt_rate       <= cmd.tilt_rate;
            item_r.position_meas   <= cmd.position_meas;
            item_r.diff_side_meas  <= cmd.diff_side_meas;
            item_r.battery_mv      <= cmd.battery_mv;
            state <= S_CTL;
          end
        end
        S_CTL: begin
          mac_start <= 1'b1;
          state     <= S_MUL;
        end
        S_MUL: begin
          if (mac_done) begin
            dvd_r     <= item_r.tilt_angle - signed'(mac_acc);
            dsr_r     <= adsr;
            div_start <= 1'b1;
            state     <= S_DIVA;
          end
        end
        S_DIVA: begin
          if (div_done) begin
            by_angle  <= div_quo;
            dvd_r     <= item_r.tilt_rate;
            dsr_r     <= rdsr;
            div_start <= 1'b1;
            state     <= S_DIVR;
          end
        end
        S_DIVR: begin
          if (div_done) begin
            by_rate <= div_quo;
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_valid || res.ready) begin
            res.power_left        <= by_rate - by_angle - item_r.diff_side_meas;
            res.power_right       <= by_rate - by_angle + item_r.diff_side_meas;
            res.position_setpoint <= stat.position_set;
            res.turn_setpoint     <= stat.turn_set;
            res.override_active   <= stat.override_active;
            res_valid             <= 1'b1;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("second transaction taken while a tick is in progress");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state == S_OUT))
    else $error("result raised outside the output step");

  a_div_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVA || state == S_DIVR))
    else $error("divider finished while the sequencer is not waiting for it");

endmodule

### tb/bal_motor_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Balance controller checker
// Watches the measurement, configuration and motor power channels, predicts
// each tick's motor power and setpoints and compares every result with it.
// ----------------------------------------------------------------------------
module bal_motor_checker
  import bal_pkg::*;
(
  input  logic clk,
  input  logic rst,
  bal_cmd_if   cmd,
  bal_res_if   res,
  bal_cfg_if   cfg,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    logic signed [15:0] power_left;
    logic signed [15:0] power_right;
    logic signed [15:0] position_setpoint;
    logic signed [15:0] turn_setpoint;
    logic               override_active;
  } motor_out_t;

  motor_out_t power_q[$];

  // Local copy of the registers.
  longint speed_gain_r, position_gain_r, angle_div_r, rate_div_r, hold_r;
  bit     autonomous_r;

  // Local copy of the controller state.
  longint pos_set, turn_set, last_remote, turn_dir;
  longint remote_cnt, avoid_cnt, ovr_cnt;

  function automatic longint wrap(longint v, int w);
    return (v <<< (64 - w)) >>> (64 - w);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int sign_of(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  // Advance the controller state by one tick and queue the motor outputs.
  task automatic predict_tick(input item_t t);
    longint remote, front, speed, wsum, angle, rate, pm, sm, batt;
    longint p, drive, turn, target, diff, by_angle, by_rate, adiv, rdiv;
    motor_out_t o;
    remote = t.remote_value;
    front  = t.front_distance;
    speed  = t.body_speed;
    wsum   = t.wheel_speed_sum;
    angle  = t.tilt_angle;
    rate   = t.tilt_rate;
    pm     = t.position_meas;
    sm     = t.diff_side_meas;
    batt   = t.battery_mv;

    if (t.cmd_flags[2]) remote_cnt = hold_r;

    if (remote_cnt != 0) begin
      remote_cnt--;
      p = clamp(remote * 20, last_remote - SlewStep, last_remote + SlewStep);
      p = clamp(p, -PosLimit, PosLimit);
      pos_set = p;
      last_remote = p;
      avoid_cnt = AvoidLoad;
    end else if (autonomous_r) begin
      drive = clamp(front / DistDiv - 2, -2, 5);
      turn  = t.left_farther ? 1 : -1;
      if (speed < -StillBand) begin
        avoid_cnt = AvoidLoad;
        turn_dir = t.tick_parity ? -2 : 2;
      end
      if (t.cmd_flags[0]) avoid_cnt = AvoidLoad;
      if (avoid_cnt != 0) avoid_cnt--;
      else if (drive <= 0) turn = turn_dir;
      pos_set  = wrap(pos_set + drive, 16);
      turn_set = wrap(turn_set + turn, 16);
    end

    if (t.cmd_flags[0]) begin
      pos_set = 0;
      turn_set = 0;
    end

    // Recovery override countdown with early end when upright and still.
    if (t.cmd_flags[1]) ovr_cnt = (batt > BattMin) ? OvrLoad : 0;
    if (ovr_cnt != 0) ovr_cnt--;
    if (ovr_cnt != 0) pos_set = 0;
    if (ovr_cnt != 0 && angle < UprightBand && angle > -UprightBand &&
        speed < StillBand && speed > -StillBand && sign_of(angle) == sign_of(rate))
      ovr_cnt = 0;

    target   = wrap(wsum * speed_gain_r + pm * position_gain_r, 32);
    diff     = wrap(angle - target, 32);
    adiv     = (angle_div_r != 0) ? angle_div_r : 1;
    rdiv     = (rate_div_r != 0) ? rate_div_r : 1;
    by_angle = wrap(diff / adiv / ((ovr_cnt != 0) ? 24 : 16), 16);
    by_rate  = wrap(rate / rdiv / 256, 16);

    o.power_left        = 16'(-by_angle + by_rate - sm);
    o.power_right       = 16'(-by_angle + by_rate + sm);
    o.position_setpoint = 16'(pos_set);
    o.turn_setpoint     = 16'(turn_set);
    o.override_active   = (ovr_cnt != 0);
    power_q.push_back(o);
  endtask

  task automatic report(input string field, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    errors++;
  endtask

  assign pending = power_q.size();

  // Track every transaction on the three channels.
  always @(posedge clk) begin
    motor_out_t want;
    if (rst) begin
      power_q.delete();
      errors       = 0;
      speed_gain_r = 0; position_gain_r = 0;
      angle_div_r  = 1; rate_div_r = 1;
      autonomous_r = 0; hold_r = 100;
      pos_set = 0; turn_set = 0; last_remote = 0; turn_dir = 0;
      remote_cnt = 0; avoid_cnt = 0; ovr_cnt = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_idx_t'(cfg.index))
          CfgSpeedGain:    speed_gain_r    = longint'($signed(cfg.data));
          CfgPositionGain: position_gain_r = longint'($signed(cfg.data));
          CfgAngleDivisor: angle_div_r     = cfg.data[14:0];
          CfgRateDivisor:  rate_div_r      = cfg.data[14:0];
          CfgAutonomous:   autonomous_r    = cfg.data[0];
          CfgRemoteHold:   hold_r          = cfg.data[14:0];
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        predict_tick('{cmd.cmd_flags, cmd.remote_value, cmd.front_distance,
                       cmd.left_farther, cmd.tick_parity, cmd.body_speed,
                       cmd.wheel_speed_sum, cmd.tilt_angle, cmd.tilt_rate,
                       cmd.position_meas, cmd.diff_side_meas, cmd.battery_mv});
      end
      if (res.valid && res.ready) begin
        if (power_q.size() == 0) begin
          $display("%0t: motor power transaction with none expected", $realtime);
          errors++;
        end else begin
          want = power_q.pop_front();
          if (res.power_left !== want.power_left)
            report("power_left", res.power_left, want.power_left);
          if (res.power_right !== want.power_right)
            report("power_right", res.power_right, want.power_right);
          if (res.position_setpoint !== want.position_setpoint)
            report("position_setpoint", res.position_setpoint, want.position_setpoint);
          if (res.turn_setpoint !== want.turn_setpoint)
            report("turn_setpoint", res.turn_setpoint, want.turn_setpoint);
          if (res.override_active !== want.override_active)
            report("override_active", res.override_active, want.override_active);
        end
      end
    end
  end

endmodule

### tb/tb_balance_robot_motor_control_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Balancing motor control testbench
// Directed and random control ticks under several register settings, with
// random gaps on the measurement side and random stalls on the power side.
// ----------------------------------------------------------------------------
module tb_balance_robot_motor_control_top;
  import bal_pkg::*;

  localparam int StallLimit = 3000;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   quiet_cycles;
  bit   calm;

  bal_cmd_if cmd_ch ();
  bal_res_if res_ch ();
  bal_cfg_if cfg_ch ();

  balance_robot_motor_control_top DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  bal_motor_checker checker_i (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .res     (res_ch),
    .cfg     (cfg_ch),
    .errors  (errors),
    .pending (pending)
  );

  // 8 ns clock.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  // Hold off for a random number of cycles, then send one register write.
  // Valid stays up after the write; the caller drops it after the last one.
  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      cfg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    forever begin
      @(negedge clk);
      if (cfg_ch.ready) break;
    end
    @(posedge clk);
  endtask

  // Send one tick of measurements; valid stays up when no gap follows.
  task automatic send_tick(input item_t t);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid           <= 1'b1;
    cmd_ch.cmd_flags       <= t.cmd_flags;
    cmd_ch.remote_value    <= t.remote_value;
    cmd_ch.front_distance  <= t.front_distance;
    cmd_ch.left_farther    <= t.left_farther;
    cmd_ch.tick_parity     <= t.tick_parity;
    cmd_ch.body_speed      <= t.body_speed;
    cmd_ch.wheel_speed_sum <= t.wheel_speed_sum;
    cmd_ch.tilt_angle      <= t.tilt_angle;
    cmd_ch.tilt_rate       <= t.tilt_rate;
    cmd_ch.position_meas   <= t.position_meas;
    cmd_ch.diff_side_meas  <= t.diff_side_meas;
    cmd_ch.battery_mv      <= t.battery_mv;
    forever begin
      @(negedge clk);
      if (cmd_ch.ready) break;
    end
    @(posedge clk);
  endtask

  task automatic tick(input logic [2:0] flags, input int remote, input int front,
                      input bit lf, input bit par, input int speed, input int wsum,
                      input int angle, input int rate, input int pm, input int sm,
                      input int batt);
    send_tick('{flags, 16'(remote), 16'(front), lf, par, 16'(speed), 17'(wsum),
                angle, rate, 16'(pm), 16'(sm), 16'(batt)});
  endtask

  // Random tick, mostly near upright so that the override can end early.
  function automatic item_t draw_tick(input bit rare_remote);
    item_t t;
    t.cmd_flags[2]    = rare_remote ? ($urandom_range(0, 39) == 0)
                                    : ($urandom_range(0, 7) == 0);
    t.cmd_flags[1]    = ($urandom_range(0, 9) == 0);
    t.cmd_flags[0]    = ($urandom_range(0, 15) == 0);
    t.remote_value    = $urandom_range(0, 1) ? 16'(int'($urandom_range(0, 600)) - 300)
                                             : 16'($urandom);
    t.front_distance  = $urandom_range(0, 1) ? 16'($urandom_range(0, 2500)) : 16'($urandom);
    t.left_farther    = $urandom_range(0, 1);
    t.tick_parity     = $urandom_range(0, 1);
    t.body_speed      = $urandom_range(0, 1) ? 16'(int'($urandom_range(0, 300)) - 150)
                                             : 16'($urandom);
    t.wheel_speed_sum = 17'(int'($urandom_range(0, 131070)) - 65536);
    t.tilt_angle      = ($urandom_range(0, 9) < 6) ? int'($urandom_range(0, 1000000)) - 500000
                                                   : int'($urandom);
    t.tilt_rate       = $urandom_range(0, 1) ? int'($urandom_range(0, 4000)) - 2000
                                             : int'($urandom);
    t.position_meas   = 16'($urandom);
    t.diff_side_meas  = 16'($urandom);
    t.battery_mv      = $urandom_range(0, 1) ? 16'($urandom_range(14000, 15000))
                                             : 16'($urandom);
    return t;
  endfunction

  // Stop sending and wait until every expected result has come.
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_all(input int sg, input int pg, input int ad, input int rd,
                         input bit auto_on, input int hold);
    write_reg(CfgSpeedGain, 16'(sg));
    write_reg(CfgPositionGain, 16'(pg));
    write_reg(CfgAngleDivisor, 16'(ad));
    write_reg(CfgRateDivisor, 16'(rd));
    write_reg(CfgAutonomous, 16'(auto_on));
    write_reg(CfgRemoteHold, 16'(hold));
    cfg_ch.valid <= 1'b0;
  endtask

  // Result side: random stalls, with stretches of none.
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      forever begin
        @(negedge clk);
        if (res_ch.valid) break;
      end
      @(posedge clk);
    end
  end

  // Watchdog on cycles with no transaction on any channel.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus and verdict.
  initial begin
    int sg, pg, ad, rd, hold;
    bit auto_on;
    quiet_cycles = 0;
    calm = 1'b0;
    rst <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.cmd_flags <= '0;
    cmd_ch.remote_value <= '0;
    cmd_ch.front_distance <= '0;
    cmd_ch.left_farther <= 1'b0;
    cmd_ch.tick_parity <= 1'b0;
    cmd_ch.body_speed <= '0;
    cmd_ch.wheel_speed_sum <= '0;
    cmd_ch.tilt_angle <= '0;
    cmd_ch.tilt_rate <= '0;
    cmd_ch.position_meas <= '0;
    cmd_ch.diff_side_meas <= '0;
    cmd_ch.battery_mv <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CfgSpeedGain;
    cfg_ch.data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed ticks under reset settings: extremes, remote slew, override.
    tick(3'b000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    tick(3'b000, 32767, 65535, 1, 1, 32767, 65534, 32'h7fffffff, 32'h7fffffff,
         32767, 32767, 65535);
    tick(3'b000, -32768, 0, 0, 0, -32768, -65536, 32'h80000000, 32'h80000000,
         -32768, -32768, 0);
    tick(3'b100, 32767, 0, 0, 0, 0, 0, 1000, -1000, 0, 5, 0);
    tick(3'b000, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    tick(3'b100, -32768, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    tick(3'b010, 0, 0, 0, 0, 500, 0, 2000000, 5, 0, 0, 14501);
    tick(3'b000, 0, 0, 0, 0, 0, 0, 300000, 100, 0, 0, 0);
    tick(3'b010, 0, 0, 0, 0, 0, 0, 1000000, 5, 0, 0, 14500);
    tick(3'b010, 0, 0, 0, 0, 99, 0, -449999, -3, 0, 0, 65535);
    tick(3'b111, 100, 0, 0, 0, 0, 0, 0, 0, 0, 0, 20000);
    tick(3'b001, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    drain();

    // Directed autonomous ticks: drive limits, avoid timeout, turn direction.
    set_all(3, -2, 0, 0, 1'b1, 0);
    tick(3'b000, 0, 0, 1, 0, -101, 100, 4000, 300, 7, -7, 0);
    tick(3'b000, 0, 65535, 0, 1, -101, 0, 0, 0, 0, 0, 0);
    tick(3'b001, 0, 3000, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    tick(3'b000, 0, 602, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    tick(3'b000, 0, 2408, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    drain();

    // Random phases under several register settings.
    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 3);
      case (ph)
        0: begin sg = 0;      pg = 0;      ad = 1;     rd = 1;     auto_on = 0; hold = 100;   end
        1: begin sg = 32767;  pg = -32768; ad = 32767; rd = 32767; auto_on = 1; hold = 0;     end
        2: begin sg = -32768; pg = 32767;  ad = 1;     rd = 1;     auto_on = 1; hold = 5;     end
        3: begin sg = 7;      pg = -3;     ad = 4;     rd = 2;     auto_on = 0; hold = 32767; end
        default: begin
          sg = int'($urandom_range(0, 65535)) - 32768;
          pg = int'($urandom_range(0, 65535)) - 32768;
          ad = $urandom_range(1, 32767);
          rd = $urandom_range(1, 32767);
          auto_on = $urandom_range(0, 1);
          hold = $urandom_range(0, 40);
        end
      endcase
      set_all(sg, pg, ad, rd, auto_on, hold);
      for (int n = 0; n < 115; n++) begin
        send_tick(draw_tick(auto_on));
        // Let the block run dry once mid-phase.
        if (n == 60 && ph == 1) drain();
      end
      drain();
    end

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/bal_pkg.sv
rtl/core/bal_cmd_if.sv
rtl/core/bal_res_if.sv
rtl/core/bal_cfg_if.sv
rtl/core/bal_ctl.sv
rtl/core/bal_mac.sv
rtl/core/bal_div.sv
rtl/core/balance_robot_motor_control_top.sv
tb/bal_motor_checker.sv
tb/tb_balance_robot_motor_control_top.sv
